@@ sv/sats_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sats_pkg;

	// Default grid limits
	localparam int SATS_MAX_WIDTH  = 64;
	localparam int SATS_MAX_HEIGHT = 64;

	// Field widths
	localparam int OP_W        = 2;
	localparam int IDX_W       = 12;
	localparam int GEN_W       = 32;
	localparam int LIVE_W      = 13;
	localparam int CFG_DATA_W  = 7;
	localparam int CFG_INDEX_W = 1;

	// Operation codes
	localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OP_W-1:0] OP_READ    = 2'd1;
	localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'b1;

	localparam logic [CFG_DATA_W-1:0] GRID_DIM_RESET = 7'd64;
	localparam logic [LIVE_W-1:0]     LIVE_MAX       = 13'h1FFF;
	localparam logic [3:0]            BIRTH_COUNT    = 4'd2;

	// Row slots of one window column, in read order
	localparam logic [1:0] SLOT_UP  = 2'd0;
	localparam logic [1:0] SLOT_MID = 2'd1;
	localparam logic [1:0] SLOT_DN  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [IDX_W-1:0] cell_index;
		logic             load_value;
	} sats_request_t;

	typedef struct packed {
		logic              cell_value;
		logic [GEN_W-1:0]  generation;
		logic [LIVE_W-1:0] live_cells;
	} sats_result_t;

	// Sequencer to window: one read in flight
	typedef struct packed {
		logic       capture;
		logic [1:0] slot;
		logic       emit;
	} sats_win_ctl_t;

	// Window to sequencer: next-generation cell ready to write
	typedef struct packed {
		logic emit;
		logic live;
	} sats_win_out_t;

endpackage

`default_nettype wire

@@ sv/sats_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sats_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ sv/sats_rule.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sats_rule import sats_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sats_win_ctl_t ctl,
	input  wire logic          cell_bit,
	output sats_win_out_t      win_out
);

	// Column bits: [2] row above, [1] own row, [0] row below
	logic       up_q;
	logic       mid_q;
	logic [2:0] col_l_q;
	logic [2:0] col_m_q;
	logic [2:0] col_r_q;
	logic       emit_s2;
	logic [3:0] nbr;

	// Gather one column, then slide the 3x3 window
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			case (ctl.slot)
				SLOT_UP: begin
					up_q <= cell_bit;
				end
				SLOT_MID: begin
					mid_q <= cell_bit;
				end
				default: begin
					col_l_q <= col_m_q;
					col_m_q <= col_r_q;
					col_r_q <= {up_q, mid_q, cell_bit};
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
		end else begin
			emit_s2 <= ctl.capture && (ctl.slot == SLOT_DN) && ctl.emit;
		end
	end

	// B2/S: dead center with exactly two live neighbors is born
	assign nbr = 4'(col_l_q[2]) + 4'(col_l_q[1]) + 4'(col_l_q[0])
		+ 4'(col_m_q[2]) + 4'(col_m_q[0])
		+ 4'(col_r_q[2]) + 4'(col_r_q[1]) + 4'(col_r_q[0]);

	assign win_out.emit = emit_s2;
	assign win_out.live = !col_m_q[1] && (nbr == BIRTH_COUNT);

endmodule

`default_nettype wire

@@ sv/seeds_automaton_torus_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

// B2/S automaton on a wrapping grid of grid_width x grid_height cells, stored
// flat (row * width + column) in two one-bit RAMs that swap roles on each
// advance. Load and unused codes answer in the next cycle; a read passes
// through the READ state before its result. During an advance the single
// read port fetches three cells per window column, then the rest of the
// back buffer is zeroed. After reset the block clears all MAX_WIDTH*MAX_HEIGHT
// cells with busy high. The result strobe (done) lasts one cycle and cannot be
// held off; a new start may be taken in that cycle.
module seeds_automaton_torus_step import sats_pkg::*; #(
	parameter int MAX_WIDTH  = SATS_MAX_WIDTH,
	parameter int MAX_HEIGHT = SATS_MAX_HEIGHT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire sats_request_t          request,
	output logic                        done,
	output sats_result_t                result,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int PTR_W  = $clog2(CELLS + 1);
	localparam int AREA_W = $clog2(CELLS + 1);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int HW     = $clog2(MAX_HEIGHT + 1);
	localparam int JW     = $clog2(MAX_WIDTH + 2);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_DRAIN,
		ST_TAIL
	} state_t;

	state_t state_q;

	logic [CFG_DATA_W-1:0] grid_width_q;
	logic [CFG_DATA_W-1:0] grid_height_q;
	logic [WW-1:0]         w_eff;
	logic [HW-1:0]         h_eff;
	logic [AREA_W-1:0]     area;
	logic [31:0]           idx32;
	logic                  idx_hit;

	logic                  bank_q;
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [LIVE_W-1:0]     live_cnt_q;
	logic [GEN_W-1:0]      gen_q;
	logic [LIVE_W-1:0]     live_q;
	logic                  read_hit_q;
	logic                  done_q;
	sats_result_t          result_q;

	logic [ADDR_W-1:0]     base_up_q;
	logic [ADDR_W-1:0]     base_mid_q;
	logic [ADDR_W-1:0]     base_dn_q;
	logic [HW-1:0]         dn_row_q;
	logic [HW-1:0]         row_q;
	logic [WW-1:0]         col_q;
	logic [JW-1:0]         jc_q;
	logic [1:0]            slot_q;
	sats_win_ctl_t         ctl_s1;
	sats_win_out_t         win_out;

	logic [ADDR_W-1:0]     rd_addr;
	logic                  rd0;
	logic                  rd1;
	logic                  rd_bit;
	logic                  wr_cur;
	logic                  wr_nxt;
	logic [ADDR_W-1:0]     wr_addr;
	logic                  wr_data;
	logic                  dn_wrap;
	logic [WW-1:0]         col_nx;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_DIM_RESET;
			grid_height_q <= GRID_DIM_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_GRID_WIDTH: begin
					grid_width_q <= cfg_data;
				end
				REG_GRID_HEIGHT: begin
					grid_height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Clamp dimensions into 1..MAX
	always_comb begin
		if (grid_width_q == '0) begin
			w_eff = WW'(1);
		end else if (int'(grid_width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(grid_width_q);
		end
		if (grid_height_q == '0) begin
			h_eff = HW'(1);
		end else if (int'(grid_height_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(grid_height_q);
		end
	end

	assign area    = AREA_W'(32'(w_eff) * 32'(h_eff));
	assign idx32   = 32'(request.cell_index);
	assign idx_hit = idx32 < 32'(area);

	// Scan stepping helpers
	assign dn_wrap = (32'(dn_row_q) + 32'd1) == 32'(h_eff);
	assign col_nx  = ((32'(col_q) + 32'd1) == 32'(w_eff)) ? '0 : col_q + WW'(1);

	// Read address: request index when idle, window cell while scanning
	always_comb begin
		case (state_q)
			ST_SCAN: begin
				case (slot_q)
					SLOT_UP:  rd_addr = base_up_q + ADDR_W'(col_q);
					SLOT_MID: rd_addr = base_mid_q + ADDR_W'(col_q);
					default:  rd_addr = base_dn_q + ADDR_W'(col_q);
				endcase
			end
			default: begin
				rd_addr = idx32[ADDR_W-1:0];
			end
		endcase
	end

	// Write port: current bank for clear and load, back bank for the new generation
	always_comb begin
		wr_cur  = 1'b0;
		wr_nxt  = 1'b0;
		wr_addr = wr_ptr_q[ADDR_W-1:0];
		wr_data = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				wr_cur = 1'b1;
			end
			ST_IDLE: begin
				if (start && (request.operation == OP_LOAD) && idx_hit) begin
					wr_cur  = 1'b1;
					wr_addr = idx32[ADDR_W-1:0];
					wr_data = request.load_value;
				end
			end
			ST_TAIL: begin
				wr_nxt = (wr_ptr_q != PTR_W'(CELLS));
			end
			default: begin
			end
		endcase
		if (win_out.emit) begin
			wr_nxt  = 1'b1;
			wr_data = win_out.live;
		end
	end

	sats_ram #(
		.WIDTH(1),
		.DEPTH(CELLS)
	) u_ram0 (
		.clk  (clk),
		.we   (bank_q ? wr_nxt : wr_cur),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd0)
	);

	sats_ram #(
		.WIDTH(1),
		.DEPTH(CELLS)
	) u_ram1 (
		.clk  (clk),
		.we   (bank_q ? wr_cur : wr_nxt),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd1)
	);

	assign rd_bit = bank_q ? rd1 : rd0;

	sats_rule u_rule (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_s1),
		.cell_bit(rd_bit),
		.win_out (win_out)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			bank_q     <= 1'b0;
			wr_ptr_q   <= '0;
			live_cnt_q <= '0;
			gen_q      <= '0;
			live_q     <= '0;
			read_hit_q <= 1'b0;
			done_q     <= 1'b0;
			result_q   <= '0;
			base_up_q  <= '0;
			base_mid_q <= '0;
			base_dn_q  <= '0;
			dn_row_q   <= '0;
			row_q      <= '0;
			col_q      <= '0;
			jc_q       <= '0;
			slot_q     <= SLOT_UP;
			ctl_s1     <= '0;
		end else begin
			done_q <= 1'b0;
			ctl_s1 <= '0;

			// New-generation cell written this cycle
			if (win_out.emit) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
				if (win_out.live && (live_cnt_q != LIVE_MAX)) begin
					live_cnt_q <= live_cnt_q + LIVE_W'(1);
				end
			end

			case (state_q)
				ST_CLEAR: begin
					wr_ptr_q <= wr_ptr_q + PTR_W'(1);
					if (wr_ptr_q == PTR_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						case (request.operation)
							OP_READ: begin
								read_hit_q <= idx_hit;
								state_q    <= ST_READ;
							end
							OP_ADVANCE: begin
								wr_ptr_q   <= '0;
								live_cnt_q <= '0;
								base_up_q  <= ADDR_W'(area - AREA_W'(w_eff));
								base_mid_q <= '0;
								if (h_eff == HW'(1)) begin
									base_dn_q <= '0;
									dn_row_q  <= '0;
								end else begin
									base_dn_q <= ADDR_W'(w_eff);
									dn_row_q  <= HW'(1);
								end
								row_q   <= '0;
								col_q   <= w_eff - WW'(1);
								jc_q    <= '0;
								slot_q  <= SLOT_UP;
								state_q <= ST_SCAN;
							end
							default: begin
								// load, or a code with no action
								done_q   <= 1'b1;
								result_q <= '{cell_value: 1'b0, generation: gen_q,
									live_cells: live_q};
							end
						endcase
					end
				end
				ST_READ: begin
					done_q   <= 1'b1;
					result_q <= '{cell_value: read_hit_q & rd_bit, generation: gen_q,
						live_cells: live_q};
					state_q  <= ST_IDLE;
				end
				ST_SCAN: begin
					ctl_s1 <= '{capture: 1'b1, slot: slot_q, emit: (jc_q >= JW'(2))};
					if (slot_q != SLOT_DN) begin
						slot_q <= slot_q + 2'd1;
					end else begin
						slot_q <= SLOT_UP;
						if (jc_q == JW'(w_eff) + JW'(1)) begin
							// end of row: wrap column, move rows down
							jc_q  <= '0;
							col_q <= w_eff - WW'(1);
							if (row_q == h_eff - HW'(1)) begin
								state_q <= ST_DRAIN;
							end else begin
								row_q      <= row_q + HW'(1);
								base_up_q  <= base_mid_q;
								base_mid_q <= base_dn_q;
								if (dn_wrap) begin
									dn_row_q  <= '0;
									base_dn_q <= '0;
								end else begin
									dn_row_q  <= dn_row_q + HW'(1);
									base_dn_q <= base_dn_q + ADDR_W'(w_eff);
								end
							end
						end else begin
							jc_q  <= jc_q + JW'(1);
							col_q <= col_nx;
						end
					end
				end
				ST_DRAIN: begin
					if (!ctl_s1.capture && !win_out.emit) begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					if (wr_ptr_q == PTR_W'(CELLS)) begin
						bank_q   <= ~bank_q;
						gen_q    <= gen_q + GEN_W'(1);
						live_q   <= live_cnt_q;
						done_q   <= 1'b1;
						result_q <= '{cell_value: 1'b0, generation: gen_q + GEN_W'(1),
							live_cells: live_cnt_q};
						state_q  <= ST_IDLE;
					end else begin
						wr_ptr_q <= wr_ptr_q + PTR_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

@@ sv/sats_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sats_checker import sats_pkg::*; (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire sats_request_t request,
	input wire logic          done,
	input wire sats_result_t  result
);

	// Load and unused codes answer in the next cycle
	a_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.operation != OP_READ
			&& request.operation != OP_ADVANCE) |=> done)
		else $error("load request without result one cycle later");

	// Read answers after the RAM latency
	a_read: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.operation == OP_READ) |=> !done ##1 done)
		else $error("read request result timing wrong");

	// Advance holds the block busy and does not answer at once
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.operation == OP_ADVANCE) |=> (busy && !done))
		else $error("advance request not taken into scan");

	// Generation moves only with a result, and only by one
	a_gen: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(result.generation) |->
			(done && result.generation == $past(result.generation) + 32'd1))
		else $error("generation changed without an advance result");

	// Live count moves only with a result
	a_live: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(result.live_cells) |-> done)
		else $error("live count changed outside a result");

endmodule

bind seeds_automaton_torus_step sats_checker u_sats_checker (.*);

`default_nettype wire

@@ tb/seeds_automaton_torus_step_test.sv @@
`timescale 1ns / 1ps

module seeds_automaton_torus_step_test;
	import sats_pkg::*;

	localparam int GRID_CELLS  = SATS_MAX_WIDTH * SATS_MAX_HEIGHT;
	localparam int RAND_ITEMS  = 114;
	// longest silent stretch: above a full-size advance and the reset clear pass
	localparam int STALL_LIMIT = 60000;

	typedef struct {
		bit                     is_cfg;
		logic [CFG_INDEX_W-1:0] reg_idx;
		logic [CFG_DATA_W-1:0]  reg_val;
		sats_request_t          req;
		bit                     typed;
		sats_result_t           typed_res;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	sats_request_t          request;
	logic                   done;
	sats_result_t           result;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// predictor state
	logic [CFG_DATA_W-1:0] width_reg;
	logic [CFG_DATA_W-1:0] height_reg;
	bit                    grid_bits [GRID_CELLS];
	logic [GEN_W-1:0]      gen_count;
	logic [LIVE_W-1:0]     live_total;

	sats_result_t pending_results [$];
	stim_row_t    directed_rows [$];
	sats_result_t head;
	int           mismatches;
	int           idle_cycles;
	bit           calm;

	seeds_automaton_torus_step dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// register value as the block uses it: 0 means 1, above max means max
	function automatic int active_dim(input logic [CFG_DATA_W-1:0] v, input int maxv);
		if (v == 0)
			return 1;
		if (int'(v) > maxv)
			return maxv;
		return int'(v);
	endfunction

	// one request against the predictor state; returns its result
	function automatic sats_result_t b2s_outcome(input sats_request_t req);
		sats_result_t res;
		int           w;
		int           h;
		int           area;
		int           n;
		int unsigned  born;
		bit           nxt [GRID_CELLS];
		w    = active_dim(width_reg, SATS_MAX_WIDTH);
		h    = active_dim(height_reg, SATS_MAX_HEIGHT);
		area = w * h;
		res.cell_value = 1'b0;
		case (req.operation)
			OP_LOAD: begin
				if (int'(req.cell_index) < area)
					grid_bits[req.cell_index] = req.load_value;
			end
			OP_READ: begin
				if (int'(req.cell_index) < area)
					res.cell_value = grid_bits[req.cell_index];
			end
			OP_ADVANCE: begin
				// dead cell with exactly two live neighbors is born, live cells die;
				// everything outside the active area ends up cleared
				born = 0;
				foreach (nxt[i])
					nxt[i] = 1'b0;
				for (int y = 0; y < h; y++) begin
					for (int x = 0; x < w; x++) begin
						if (!grid_bits[y * w + x]) begin
							n = 0;
							// narrow torus: repeated neighbors count again
							for (int dx = -1; dx <= 1; dx++)
								for (int dy = -1; dy <= 1; dy++)
									if (dx != 0 || dy != 0)
										n += grid_bits[((y + h + dy) % h) * w + (x + w + dx) % w];
							if (n == int'(BIRTH_COUNT)) begin
								nxt[y * w + x] = 1'b1;
								born++;
							end
						end
					end
				end
				grid_bits  = nxt;
				gen_count  = gen_count + 1;
				live_total = (born > int'(LIVE_MAX)) ? LIVE_MAX : born[LIVE_W-1:0];
			end
			default: ;
		endcase
		res.generation = gen_count;
		res.live_cells = live_total;
		return res;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		stim_row_t r;
		r = '{default: '0};
		r.is_cfg  = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic stim_row_t item_row(input logic [OP_W-1:0] op,
			input logic [IDX_W-1:0] idx, input logic val);
		stim_row_t r;
		r = '{default: '0};
		r.req = '{operation: op, cell_index: idx, load_value: val};
		return r;
	endfunction

	// result known without the predictor: generation and live count still zero
	function automatic stim_row_t known_row(input logic [OP_W-1:0] op,
			input logic [IDX_W-1:0] idx, input logic val, input logic cell_bit);
		stim_row_t r;
		r = item_row(op, idx, val);
		r.typed     = 1'b1;
		r.typed_res = '{cell_value: cell_bit, generation: '0, live_cells: '0};
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// random pause before a request, skipped during the calm stretch
	task automatic idle_gap();
		if (!calm && $urandom_range(0, 99) < 8) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic issue_request(input sats_request_t req, input bit typed,
			input sats_result_t typed_res);
		sats_result_t pred;
		@(negedge clk);
		start   <= 1'b1;
		request <= req;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pred = b2s_outcome(req);
		pending_results.push_back(typed ? typed_res : pred);
	endtask

	// all results in and the block free again
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_GRID_WIDTH)
			width_reg = val;
		else
			height_reg = val;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending (%0d %0d %0d)",
					result.cell_value, result.generation, result.live_cells));
			end else begin
				head = pending_results.pop_front();
				if (result.cell_value !== head.cell_value)
					report_mismatch($sformatf("cell_value %0b, want %0b",
						result.cell_value, head.cell_value));
				if (result.generation !== head.generation)
					report_mismatch($sformatf("generation %0d, want %0d",
						result.generation, head.generation));
				if (result.live_cells !== head.live_cells)
					report_mismatch($sformatf("live_cells %0d, want %0d",
						result.live_cells, head.live_cells));
			end
		end
	end

	// watchdog on cycles with no request taken and no result
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[seeds_automaton_torus_step] ERROR");
			$finish;
		end
	end

	initial begin
		sats_request_t req;
		int            w;
		int            h;
		int            area;
		int            roll;
		int            phase_len;
		int            rand_count;
		logic [CFG_DATA_W-1:0] dims [2];

		arst_n      = 1'b0;
		start       = 1'b0;
		request     = '0;
		cfg_write   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		idle_cycles = 0;
		mismatches  = 0;
		calm        = 1'b0;
		width_reg   = GRID_DIM_RESET;
		height_reg  = GRID_DIM_RESET;
		gen_count   = '0;
		live_total  = '0;
		foreach (grid_bits[i])
			grid_bits[i] = 1'b0;

		// directed: reset state, corners, unused code, out-of-area access,
		// narrow tori and register extremes
		directed_rows.push_back(known_row(OP_READ, 12'd0, 1'b0, 1'b0));
		directed_rows.push_back(known_row(OP_READ, 12'd4095, 1'b0, 1'b0));
		directed_rows.push_back(known_row(2'd3, 12'd4095, 1'b1, 1'b0));
		directed_rows.push_back(known_row(OP_LOAD, 12'd0, 1'b1, 1'b0));
		directed_rows.push_back(known_row(OP_LOAD, 12'd4095, 1'b1, 1'b0));
		directed_rows.push_back(known_row(OP_READ, 12'd4095, 1'b0, 1'b1));
		directed_rows.push_back(item_row(OP_ADVANCE, 12'd0, 1'b0));
		directed_rows.push_back(item_row(OP_READ, 12'd63, 1'b0));
		directed_rows.push_back(cfg_row(REG_GRID_WIDTH, 7'd3));
		directed_rows.push_back(cfg_row(REG_GRID_HEIGHT, 7'd3));
		directed_rows.push_back(item_row(OP_LOAD, 12'd9, 1'b1));
		directed_rows.push_back(item_row(OP_READ, 12'd9, 1'b0));
		directed_rows.push_back(item_row(OP_LOAD, 12'd0, 1'b1));
		directed_rows.push_back(item_row(OP_LOAD, 12'd4, 1'b1));
		directed_rows.push_back(item_row(OP_ADVANCE, 12'hfff, 1'b1));
		directed_rows.push_back(item_row(OP_READ, 12'd1, 1'b0));
		directed_rows.push_back(item_row(OP_ADVANCE, 12'd0, 1'b0));
		directed_rows.push_back(cfg_row(REG_GRID_WIDTH, 7'd0));
		directed_rows.push_back(cfg_row(REG_GRID_HEIGHT, 7'd127));
		directed_rows.push_back(item_row(OP_LOAD, 12'd5, 1'b1));
		directed_rows.push_back(item_row(OP_LOAD, 12'd6, 1'b1));
		directed_rows.push_back(item_row(OP_ADVANCE, 12'd0, 1'b0));
		directed_rows.push_back(item_row(OP_READ, 12'd4, 1'b0));
		directed_rows.push_back(cfg_row(REG_GRID_WIDTH, 7'd2));
		directed_rows.push_back(cfg_row(REG_GRID_HEIGHT, 7'd1));
		directed_rows.push_back(item_row(OP_LOAD, 12'd0, 1'b1));
		directed_rows.push_back(item_row(OP_ADVANCE, 12'd0, 1'b0));
		directed_rows.push_back(item_row(OP_READ, 12'd1, 1'b0));
		directed_rows.push_back(item_row(2'd3, 12'd0, 1'b0));
		directed_rows.push_back(cfg_row(REG_GRID_WIDTH, 7'd127));
		directed_rows.push_back(cfg_row(REG_GRID_HEIGHT, 7'd0));
		directed_rows.push_back(item_row(OP_LOAD, 12'd0, 1'b1));
		directed_rows.push_back(item_row(OP_ADVANCE, 12'd0, 1'b0));
		directed_rows.push_back(item_row(OP_READ, 12'd63, 1'b0));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				drain();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
			end else begin
				idle_gap();
				issue_request(directed_rows[i].req, directed_rows[i].typed,
					directed_rows[i].typed_res);
			end
		end

		// random phases: one grid size each, then loads, reads, advances and unused codes
		rand_count = 0;
		while (rand_count < RAND_ITEMS) begin
			for (int d = 0; d < 2; d++) begin
				if ($urandom_range(0, 99) < 70) begin
					dims[d] = CFG_DATA_W'($urandom_range(1, 10));
				end else begin
					case ($urandom_range(0, 6))
						0: dims[d] = 7'd0;
						1: dims[d] = 7'd1;
						2: dims[d] = 7'd2;
						3: dims[d] = 7'd64;
						4: dims[d] = 7'd127;
						5: dims[d] = CFG_DATA_W'($urandom_range(0, 127));
						default: dims[d] = CFG_DATA_W'($urandom_range(3, 16));
					endcase
				end
			end
			drain();
			write_reg(REG_GRID_WIDTH, dims[0]);
			write_reg(REG_GRID_HEIGHT, dims[1]);
			w    = active_dim(width_reg, SATS_MAX_WIDTH);
			h    = active_dim(height_reg, SATS_MAX_HEIGHT);
			area = w * h;
			phase_len = $urandom_range(8, 18);
			for (int k = 0; k < phase_len && rand_count < RAND_ITEMS; k++) begin
				calm = (rand_count >= 50 && rand_count < 90);
				req.cell_index = IDX_W'($urandom_range(0, 4095));
				req.load_value = 1'($urandom_range(0, 1));
				roll = $urandom_range(0, 99);
				if (roll < 40) begin
					// mostly live cells so that births happen
					req.operation  = OP_LOAD;
					req.cell_index = IDX_W'($urandom_range(0, area - 1));
					req.load_value = ($urandom_range(0, 3) != 0);
				end else if (roll < 60) begin
					req.operation  = OP_READ;
					req.cell_index = IDX_W'($urandom_range(0, area - 1));
				end else if (roll < 78) begin
					req.operation = OP_ADVANCE;
				end else if (roll < 86) begin
					req.operation = 2'd3;
				end else if (roll < 93) begin
					req.operation = OP_LOAD;
				end else begin
					req.operation = OP_READ;
				end
				idle_gap();
				issue_request(req, 1'b0, '0);
				rand_count++;
			end
		end

		drain();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("[seeds_automaton_torus_step] OK");
		else
			$display("[seeds_automaton_torus_step] ERROR");
		$finish;
	end

endmodule

@@ files.f @@
sv/sats_pkg.sv
sv/sats_ram.sv
sv/sats_rule.sv
sv/seeds_automaton_torus_step.sv
sv/sats_checker.sv
tb/seeds_automaton_torus_step_test.sv
